// ----- design/user_based_rating_predictor_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the user based rating predictor
// Immediate-implication and next-cycle-implication checks on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef USER_BASED_RATING_PREDICTOR_DEFINES_SVH
`define USER_BASED_RATING_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
`define URP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define URP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define URP_ASSERT_IMP(lbl, ante, cons, msg)
`define URP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/urp_pkg.sv -----
// ----------------------------------------------------------------------------
// urp_pkg
// Types, constants and control structs of the user based rating predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urp_pkg;

  localparam int MAX_USERS = 64;
  localparam int MAX_ITEMS = 64;
  localparam int UW        = $clog2(MAX_USERS);
  localparam int IW        = $clog2(MAX_ITEMS);
  localparam int AW        = UW + IW;

  localparam logic [1:0] CFG_NUM_USERS = 2'd0;
  localparam logic [1:0] CFG_NUM_ITEMS = 2'd1;

  localparam logic [1:0] ST_PREDICTED = 2'd0;
  localparam logic [1:0] ST_RATED     = 2'd1;
  localparam logic [1:0] ST_NO_NEIGH  = 2'd2;

  typedef struct packed {
    logic [7:0] rating;
    logic       missing;
  } in_t;

  typedef struct packed {
    logic [5:0]  item_index;
    logic [15:0] score;
    logic [1:0]  status;
    logic        last_result;
  } out_t;

  typedef enum logic [4:0] {
    S_LOAD, S_SIM_START, S_SIM_ACC, S_SIM_DRAIN, S_SQRT_GO, S_SQRT_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_SIM_WR, S_SC_TGT, S_SC_CHK_TGT, S_SC_ACC,
    S_SC_DRAIN, S_SC_CHK_DEN, S_SC_DIV_GO, S_SC_DIV_WAIT
  } state_t;

  typedef struct packed {
    logic          load_we;
    logic          tgt_we;
    logic [UW-1:0] user;
    logic [IW-1:0] item;
    logic          clr_d;
    logic          acc_sim;
    logic          sqrt_start;
    logic          div_start;
    logic          div_sel;
    logic          sim_we;
    logic          clr_sc;
    logic          acc_sc;
    logic          emit;
    logic [1:0]    emit_status;
    logic          emit_last;
  } cmd_t;

  typedef struct packed {
    logic tgt_missing;
    logic sqrt_done;
    logic div_done;
    logic den_zero;
  } stat_t;

endpackage

// ----- design/urp_ram.sv -----
// ----------------------------------------------------------------------------
// urp_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/urp_datapath.sv -----
// ----------------------------------------------------------------------------
// urp_datapath
// Rating stores, distance and score accumulators, square root and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urp_datapath (
  input  logic          clk,
  input  logic          rst,
  input  urp_pkg::in_t  sample,
  input  urp_pkg::cmd_t cmd,
  output urp_pkg::stat_t stat,
  output urp_pkg::out_t result,
  output logic          result_valid
);

  logic [8:0]  main_rd;
  logic [8:0]  tgt_rd;
  logic [16:0] sim_rd;

  logic        acc_sim_v;
  logic        acc_sc_v;
  logic [22:0] d;
  logic [30:0] num;
  logic [22:0] den;

  logic [39:0] sq_val;
  logic [23:0] sq_rem;
  logic [19:0] sq_root;
  logic [4:0]  sq_cnt;
  logic        sq_busy;
  logic        sq_done;

  logic [34:0] dv_q;
  logic [23:0] dv_rem;
  logic [23:0] dv_den;
  logic [5:0]  dv_cnt;
  logic        dv_busy;
  logic        dv_done;

  logic signed [8:0]  diff;
  logic signed [17:0] sqr;
  logic [24:0] prod;
  logic [23:0] sq_sh;
  logic [23:0] sq_trial;
  logic [24:0] dv_sh;
  logic [20:0] sden;
  logic [34:0] div_n;
  logic [23:0] div_d;
  logic [15:0] sat;

  urp_ram #(.WIDTH(9), .DEPTH(urp_pkg::MAX_USERS * urp_pkg::MAX_ITEMS)) u_main (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr ({cmd.user, cmd.item}),
    .wdata ({sample.missing, sample.rating}),
    .raddr ({cmd.user, cmd.item}),
    .rdata (main_rd)
  );

  urp_ram #(.WIDTH(9), .DEPTH(urp_pkg::MAX_ITEMS)) u_tgt (
    .clk   (clk),
    .we    (cmd.tgt_we),
    .waddr (cmd.item),
    .wdata ({sample.missing, sample.rating}),
    .raddr (cmd.item),
    .rdata (tgt_rd)
  );

  urp_ram #(.WIDTH(17), .DEPTH(urp_pkg::MAX_USERS)) u_sim (
    .clk   (clk),
    .we    (cmd.sim_we),
    .waddr (cmd.user),
    .wdata (dv_q[16:0]),
    .raddr (cmd.user),
    .rdata (sim_rd)
  );

  always_comb begin
    diff     = $signed({1'b0, tgt_rd[7:0]}) - $signed({1'b0, main_rd[7:0]});
    sqr      = 18'(diff) * 18'(diff);
    prod     = 25'(sim_rd) * 25'(main_rd[7:0]);
    sq_sh    = {sq_rem[21:0], sq_val[39:38]};
    sq_trial = {2'b00, sq_root, 2'b01};
    dv_sh    = {dv_rem, dv_q[34]};
    sden     = {1'b0, sq_root} + 21'd4096;
    if (cmd.div_sel) begin
      div_n = {num, 4'b0000} + 35'(den[22:1]);
      div_d = {1'b0, den};
    end else begin
      div_n = 35'd268435456 + 35'(sden[20:1]);
      div_d = 24'(sden);
    end
    sat = (|dv_q[34:16]) ? 16'hFFFF : dv_q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sim_v    <= 1'b0;
      acc_sc_v     <= 1'b0;
      sq_busy      <= 1'b0;
      sq_done      <= 1'b0;
      dv_busy      <= 1'b0;
      dv_done      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      acc_sim_v    <= cmd.acc_sim;
      acc_sc_v     <= cmd.acc_sc;
      result_valid <= cmd.emit;
      sq_done      <= 1'b0;
      dv_done      <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_cnt == 5'd19) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
      if (cmd.div_start) begin
        dv_busy <= 1'b1;
      end else if (dv_busy && dv_cnt == 6'd34) begin
        dv_busy <= 1'b0;
        dv_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_d) begin
      d <= '0;
    end else if (acc_sim_v && !tgt_rd[8] && !main_rd[8]) begin
      d <= d + 23'(sqr[15:0]);
    end
    if (cmd.clr_sc) begin
      num <= '0;
      den <= '0;
    end else if (acc_sc_v && !main_rd[8]) begin
      num <= num + 31'(prod);
      den <= den + 23'(sim_rd);
    end
    // Two radicand bits enter per cycle; one root bit leaves.
    if (cmd.sqrt_start) begin
      sq_val  <= {1'b0, d, 16'h0000};
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= '0;
    end else if (sq_busy) begin
      sq_val <= {sq_val[37:0], 2'b00};
      sq_cnt <= sq_cnt + 5'd1;
      if (sq_sh >= sq_trial) begin
        sq_rem  <= sq_sh - sq_trial;
        sq_root <= {sq_root[18:0], 1'b1};
      end else begin
        sq_rem  <= sq_sh;
        sq_root <= {sq_root[18:0], 1'b0};
      end
    end
    // Restoring division, one quotient bit per cycle shifted into dv_q.
    if (cmd.div_start) begin
      dv_q   <= div_n;
      dv_den <= div_d;
      dv_rem <= '0;
      dv_cnt <= '0;
    end else if (dv_busy) begin
      dv_cnt <= dv_cnt + 6'd1;
      if (dv_sh >= {1'b0, dv_den}) begin
        dv_rem <= 24'(dv_sh - {1'b0, dv_den});
        dv_q   <= {dv_q[33:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[23:0];
        dv_q   <= {dv_q[33:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      result.item_index  <= 6'(cmd.item);
      result.score       <= (cmd.emit_status == urp_pkg::ST_PREDICTED) ? sat : 16'h0000;
      result.status      <= cmd.emit_status;
      result.last_result <= cmd.emit_last;
    end
  end

  assign stat.tgt_missing = tgt_rd[8];
  assign stat.sqrt_done   = sq_done;
  assign stat.div_done    = dv_done;
  assign stat.den_zero    = (den == '0);

endmodule

// ----- design/urp_ctrl.sv -----
// ----------------------------------------------------------------------------
// urp_ctrl
// Configuration registers, load counters and the compute sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "user_based_rating_predictor_defines.svh"

module urp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data,
  input  urp_pkg::stat_t stat,
  output urp_pkg::cmd_t  cmd
);

  urp_pkg::state_t state, state_next;
  logic [urp_pkg::UW-1:0] u, u_next;
  logic [urp_pkg::IW-1:0] j, j_next;
  logic [6:0] num_users;
  logic [6:0] num_items;
  logic [6:0] cfg_clamped;
  logic       last_u;
  logic       last_j;
  logic       cfg_wr;

  assign busy      = (state != urp_pkg::S_LOAD);
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign last_u    = (7'(u) == num_users - 7'd1);
  assign last_j    = (7'(j) == num_items - 7'd1);

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_index == urp_pkg::CFG_NUM_USERS) begin
      if (cfg_clamped < 7'd2) cfg_clamped = 7'd2;
      if (cfg_clamped > 7'(urp_pkg::MAX_USERS)) cfg_clamped = 7'(urp_pkg::MAX_USERS);
    end else begin
      if (cfg_clamped < 7'd1) cfg_clamped = 7'd1;
      if (cfg_clamped > 7'(urp_pkg::MAX_ITEMS)) cfg_clamped = 7'(urp_pkg::MAX_ITEMS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= urp_pkg::S_LOAD;
      u         <= '0;
      j         <= '0;
      num_users <= 7'd64;
      num_items <= 7'd64;
    end else begin
      state <= state_next;
      u     <= u_next;
      j     <= j_next;
      // A write to either count register discards any partial matrix.
      if (cfg_wr) begin
        if (cfg_index == urp_pkg::CFG_NUM_USERS) begin
          u         <= '0;
          j         <= '0;
          num_users <= cfg_clamped;
        end else if (cfg_index == urp_pkg::CFG_NUM_ITEMS) begin
          u         <= '0;
          j         <= '0;
          num_items <= cfg_clamped;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    u_next     = u;
    j_next     = j;
    cmd        = '0;
    cmd.user   = u;
    cmd.item   = j;
    cmd.emit_last = last_j;
    unique case (state)
      urp_pkg::S_LOAD: begin
        if (start) begin
          cmd.load_we = 1'b1;
          cmd.tgt_we  = (u == '0);
          if (last_j) begin
            j_next = '0;
            if (last_u) begin
              u_next     = urp_pkg::UW'(1);
              state_next = urp_pkg::S_SIM_START;
            end else begin
              u_next = u + urp_pkg::UW'(1);
            end
          end else begin
            j_next = j + urp_pkg::IW'(1);
          end
        end
      end
      urp_pkg::S_SIM_START: begin
        cmd.clr_d  = 1'b1;
        j_next     = '0;
        state_next = urp_pkg::S_SIM_ACC;
      end
      urp_pkg::S_SIM_ACC: begin
        cmd.acc_sim = 1'b1;
        if (last_j) begin
          j_next     = '0;
          state_next = urp_pkg::S_SIM_DRAIN;
        end else begin
          j_next = j + urp_pkg::IW'(1);
        end
      end
      urp_pkg::S_SIM_DRAIN: state_next = urp_pkg::S_SQRT_GO;
      urp_pkg::S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = urp_pkg::S_SQRT_WAIT;
      end
      urp_pkg::S_SQRT_WAIT: begin
        if (stat.sqrt_done) state_next = urp_pkg::S_DIV_GO;
      end
      urp_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = urp_pkg::S_DIV_WAIT;
      end
      urp_pkg::S_DIV_WAIT: begin
        if (stat.div_done) state_next = urp_pkg::S_SIM_WR;
      end
      urp_pkg::S_SIM_WR: begin
        cmd.sim_we = 1'b1;
        j_next     = '0;
        if (last_u) begin
          u_next     = '0;
          state_next = urp_pkg::S_SC_TGT;
        end else begin
          u_next     = u + urp_pkg::UW'(1);
          state_next = urp_pkg::S_SIM_START;
        end
      end
      urp_pkg::S_SC_TGT: begin
        cmd.clr_sc = 1'b1;
        state_next = urp_pkg::S_SC_CHK_TGT;
      end
      urp_pkg::S_SC_CHK_TGT: begin
        if (!stat.tgt_missing) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = urp_pkg::ST_RATED;
          u_next          = '0;
          j_next          = last_j ? '0 : j + urp_pkg::IW'(1);
          state_next      = last_j ? urp_pkg::S_LOAD : urp_pkg::S_SC_TGT;
        end else begin
          u_next     = urp_pkg::UW'(1);
          state_next = urp_pkg::S_SC_ACC;
        end
      end
      urp_pkg::S_SC_ACC: begin
        cmd.acc_sc = 1'b1;
        if (last_u) begin
          state_next = urp_pkg::S_SC_DRAIN;
        end else begin
          u_next = u + urp_pkg::UW'(1);
        end
      end
      urp_pkg::S_SC_DRAIN: state_next = urp_pkg::S_SC_CHK_DEN;
      urp_pkg::S_SC_CHK_DEN: begin
        if (stat.den_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = urp_pkg::ST_NO_NEIGH;
          u_next          = '0;
          j_next          = last_j ? '0 : j + urp_pkg::IW'(1);
          state_next      = last_j ? urp_pkg::S_LOAD : urp_pkg::S_SC_TGT;
        end else begin
          state_next = urp_pkg::S_SC_DIV_GO;
        end
      end
      urp_pkg::S_SC_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = urp_pkg::S_SC_DIV_WAIT;
      end
      urp_pkg::S_SC_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = urp_pkg::ST_PREDICTED;
          u_next          = '0;
          j_next          = last_j ? '0 : j + urp_pkg::IW'(1);
          state_next      = last_j ? urp_pkg::S_LOAD : urp_pkg::S_SC_TGT;
        end
      end
      default: state_next = urp_pkg::S_LOAD;
    endcase
  end

  `URP_ASSERT_NXT(a_end_of_load, start && !busy && last_u && last_j && !cfg_wr, state == urp_pkg::S_SIM_START, "last rating did not start the compute pass")
  `URP_ASSERT_NXT(a_cfg_rewind, cfg_wr && (cfg_index == urp_pkg::CFG_NUM_USERS || cfg_index == urp_pkg::CFG_NUM_ITEMS), u == '0 && j == '0, "register write did not rewind the load position")
  `URP_ASSERT_IMP(a_user_range, state == urp_pkg::S_SC_ACC || state == urp_pkg::S_SIM_ACC, 7'(u) < num_users && u != '0, "neighbour index out of range")

endmodule

// ----- design/user_based_rating_predictor.sv -----
// ----------------------------------------------------------------------------
// user_based_rating_predictor
// Rating predictor by user based collaborative filtering, Euclidean distance.
// ----------------------------------------------------------------------------
// Usage: ratings are sent one beat at a time on sample, row-major, user 0
// first, accepted on a clock edge with start high and busy low. A load
// accepts one rating per cycle. The beat that completes the num_users x
// num_items matrix raises busy; the block then computes one similarity per
// neighbour, using the 20-step square root and the 35-step divider, and one
// result per item. Each result is shown on result for one cycle with
// result_valid high; the receiver cannot stall, so results are never held.
// busy falls with the final result, and loading restarts at position zero.
// Registers are written on the cfg channel while busy is low; a write to
// either count register rewinds the load position. Reset sets both counts
// to 64 and the load position to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module user_based_rating_predictor (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  urp_pkg::in_t  sample,
  output logic          result_valid,
  output urp_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [6:0]    cfg_data
);

  urp_pkg::cmd_t  cmd;
  urp_pkg::stat_t stat;

  urp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  urp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for user_based_rating_predictor. Rating beats and
// register writes are queued by a stimulus process and sent by a driver at
// the falling edge. A predictor tracks the stored matrix and the register
// values, and works out the similarities and item scores when a matrix
// completes. The monitor compares each result beat with the oldest expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {OP_RATING, OP_WRITE, OP_WAIT_DRAIN} op_kind_t;
  typedef struct packed {
    op_kind_t      kind;
    urp_pkg::in_t  beat;
    logic [1:0]    idx;
    logic [6:0]    data;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  urp_pkg::in_t sample = '0;
  logic result_valid;
  urp_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  op_t pending_ops[$];
  urp_pkg::out_t expected_scores[$];
  op_t cur_op;
  bit driving = 0;
  bit beat_taken = 0;
  bit write_taken = 0;
  bit burst_mode = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int rating_beats = 0;

  // Predictor state
  logic [8:0] rating_mem[0:urp_pkg::MAX_USERS*urp_pkg::MAX_ITEMS-1];
  logic [16:0] sim_mem[0:urp_pkg::MAX_USERS-1];
  int unsigned load_pos = 0;
  int unsigned n_users = 64;
  int unsigned n_items = 64;

  user_based_rating_predictor u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void apply_write(logic [1:0] idx, logic [6:0] data);
    int unsigned v;
    v = data;
    if (idx == urp_pkg::CFG_NUM_USERS) begin
      n_users = (v < 2) ? 2 : (v > urp_pkg::MAX_USERS) ? urp_pkg::MAX_USERS : v;
      load_pos = 0;
    end else if (idx == urp_pkg::CFG_NUM_ITEMS) begin
      n_items = (v < 1) ? 1 : (v > urp_pkg::MAX_ITEMS) ? urp_pkg::MAX_ITEMS : v;
      load_pos = 0;
    end
  endfunction

  function automatic void score_matrix();
    longint unsigned d, r, den, num, sc;
    int diff;
    logic [8:0] t, n;
    urp_pkg::out_t o;
    for (int u = 1; u < n_users; u++) begin
      d = 0;
      for (int j = 0; j < n_items; j++) begin
        t = rating_mem[j];
        n = rating_mem[u*urp_pkg::MAX_ITEMS + j];
        if (!t[8] && !n[8]) begin
          diff = int'(t[7:0]) - int'(n[7:0]);
          d += longint'(diff * diff);
        end
      end
      r = int_sqrt(d << 16) + 4096;
      sim_mem[u] = 17'((((64'h1 << 28) + r / 2) / r));
    end
    for (int j = 0; j < n_items; j++) begin
      sc = 0;
      o.item_index = 6'(j);
      o.last_result = (j + 1 == n_items);
      if (!rating_mem[j][8]) begin
        o.status = urp_pkg::ST_RATED;
      end else begin
        num = 0;
        den = 0;
        for (int u = 1; u < n_users; u++) begin
          n = rating_mem[u*urp_pkg::MAX_ITEMS + j];
          if (!n[8]) begin
            num += longint'(sim_mem[u]) * n[7:0];
            den += sim_mem[u];
          end
        end
        if (den == 0) begin
          o.status = urp_pkg::ST_NO_NEIGH;
        end else begin
          sc = (num * 16 + den / 2) / den;
          if (sc > 65535) sc = 65535;
          o.status = urp_pkg::ST_PREDICTED;
        end
      end
      o.score = 16'(sc);
      expected_scores.push_back(o);
    end
  endfunction

  function automatic void store_rating(urp_pkg::in_t s);
    int unsigned total;
    total = n_users * n_items;
    if (load_pos >= total) load_pos = 0;
    rating_mem[(load_pos / n_items) * urp_pkg::MAX_ITEMS + load_pos % n_items] =
        {s.missing, s.rating};
    load_pos++;
    if (load_pos >= total) begin
      load_pos = 0;
      score_matrix();
    end
  endfunction

  // Sampling side: handshakes, predictor updates and result checks
  always @(posedge clk) begin
    urp_pkg::out_t want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy) begin
        store_rating(sample);
        beat_taken = 1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        write_taken = 1;
      end
      if (result_valid) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result beat: item_index %0d", result.item_index);
          fail_count++;
        end else begin
          want = expected_scores.pop_front();
          if (result.item_index !== want.item_index) begin
            $error("item_index: expected %0d, got %0d", want.item_index, result.item_index);
            fail_count++;
          end
          if (result.score !== want.score) begin
            $error("score: expected %0d, got %0d", want.score, result.score);
            fail_count++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fail_count++;
          end
          if (result.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result,
                   result.last_result);
            fail_count++;
          end
        end
      end
      if (busy || result_valid || expected_scores.size() != 0) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Driver: one op at a time, inputs updated at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (beat_taken || write_taken) begin
        beat_taken = 0;
        write_taken = 0;
        driving = 0;
        gap_left = burst_mode ? 0 : $urandom_range(0, 15);
      end
      if (!driving && pending_ops.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (pending_ops[0].kind)
            OP_RATING: begin
              cur_op = pending_ops.pop_front();
              driving = 1;
            end
            OP_WRITE: begin
              if (idle_cycles >= SETTLE_CYCLES) begin
                cur_op = pending_ops.pop_front();
                driving = 1;
                burst_mode = ($urandom_range(0, 2) == 0);
              end
            end
            default: begin
              if (idle_cycles >= SETTLE_CYCLES) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      start <= driving && cur_op.kind == OP_RATING;
      cfg_valid <= driving && cur_op.kind == OP_WRITE;
      if (driving) begin
        sample <= cur_op.beat;
        cfg_index <= cur_op.idx;
        cfg_data <= cur_op.data;
      end
    end
  end

  task automatic add_rating(logic [7:0] r, logic m);
    op_t o;
    o = '0;
    o.kind = OP_RATING;
    o.beat.rating = r;
    o.beat.missing = m;
    pending_ops.push_back(o);
    rating_beats++;
  endtask

  task automatic add_write(logic [1:0] idx, logic [6:0] data);
    op_t o;
    o = '0;
    o.kind = OP_WRITE;
    o.idx = idx;
    o.data = data;
    pending_ops.push_back(o);
  endtask

  task automatic add_drain();
    op_t o;
    o = '0;
    o.kind = OP_WAIT_DRAIN;
    pending_ops.push_back(o);
  endtask

  task automatic add_random_matrix(int users, int items);
    for (int k = 0; k < users * items; k++)
      add_rating(8'($urandom), $urandom_range(0, 9) < 3);
  endtask

  initial begin
    int users, items;
    // Clamping, spare indexes and a discarded partial load
    add_write(urp_pkg::CFG_NUM_USERS, 7'd0);
    add_write(urp_pkg::CFG_NUM_ITEMS, 7'd0);
    add_rating(8'h12, 1'b0);
    add_write(CFG_SPARE_A, 7'h7f);
    add_write(CFG_SPARE_B, 7'h55);
    add_write(urp_pkg::CFG_NUM_ITEMS, 7'd4);
    // Target: missing, 0, missing, max. Neighbour: max, max, missing, 0.
    // Covers a prediction, a rated item, an item nobody rated, and the
    // largest rating difference.
    add_rating(8'h00, 1'b1);
    add_rating(8'h00, 1'b0);
    add_rating(8'hff, 1'b1);
    add_rating(8'hff, 1'b0);
    add_rating(8'hff, 1'b0);
    add_rating(8'hff, 1'b0);
    add_rating(8'h00, 1'b1);
    add_rating(8'h00, 1'b0);
    add_drain();
    // Identical ratings give the top similarity.
    add_write(urp_pkg::CFG_NUM_USERS, 7'd3);
    add_write(urp_pkg::CFG_NUM_ITEMS, 7'd2);
    add_rating(8'h40, 1'b0);
    add_rating(8'h00, 1'b1);
    add_rating(8'h40, 1'b0);
    add_rating(8'h80, 1'b0);
    add_rating(8'hff, 1'b1);
    add_rating(8'h55, 1'b0);
    // Largest sizes, kept narrow in the other direction.
    add_write(urp_pkg::CFG_NUM_USERS, 7'h7f);
    add_write(urp_pkg::CFG_NUM_ITEMS, 7'd1);
    add_random_matrix(64, 1);
    add_write(urp_pkg::CFG_NUM_USERS, 7'd2);
    add_write(urp_pkg::CFG_NUM_ITEMS, 7'd64);
    add_random_matrix(2, 64);
    while (rating_beats < 215) begin
      users = $urandom_range(2, 5);
      items = $urandom_range(1, 6);
      add_write(urp_pkg::CFG_NUM_USERS, 7'(users));
      add_write(urp_pkg::CFG_NUM_ITEMS, 7'(items));
      if ($urandom_range(0, 5) == 0)
        add_random_matrix(1, $urandom_range(1, items));
      add_write(urp_pkg::CFG_NUM_ITEMS, 7'(items));
      repeat ($urandom_range(1, 3)) begin
        add_random_matrix(users, items);
        if ($urandom_range(0, 3) == 0) add_drain();
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && !driving);
    wait (expected_scores.size() == 0 && !busy);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_scores.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+design
design/urp_pkg.sv
design/urp_ram.sv
design/urp_datapath.sv
design/urp_ctrl.sv
design/user_based_rating_predictor.sv
sim/tb.sv
